FILE: sv/lookahead_balance_torque_top_assert.svh
// Assertion macros used by the checker file of the torque block.
`ifndef LOOKAHEAD_BALANCE_TORQUE_TOP_ASSERT_SVH
`define LOOKAHEAD_BALANCE_TORQUE_TOP_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define LBT_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("torque block assertion failed");

// Next-cycle implication, off while reset is high.
`define LBT_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("torque block assertion failed");

// Next-cycle implication that also holds through reset.
`define LBT_ASSERT_NEXT_RST(lbl, pre, post) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("torque block assertion failed");

`endif

FILE: sv/lbt_pkg.sv
// Shared types, constants and fixed-point helpers for the torque block.
package lbt_pkg;

  localparam int FRAC_BITS = 16;

  localparam logic signed [63:0] Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] Q_MIN = 64'sh8000_0000_0000_0000;
  localparam logic [127:0] MAG_LIM_P = 128'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [127:0] MAG_LIM_N = 128'h8000_0000_0000_0000;

  localparam logic [31:0] COEF_RESET = 32'(64'd1 << FRAC_BITS);
  localparam logic [31:0] K12 = 32'(((64'd12 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic signed [63:0] SIX_Q = 64'(64'd6 << FRAC_BITS);

  // multiplier: 64 x 33 signed, three stages
  localparam int MUL_B_W = 33;
  localparam int MUL_LAT = 3;

  // divider: long division, DIV_STEP quotient bits per stage
  localparam int DIV_STEP = 2;
  localparam int DIVN_W = 64 + FRAC_BITS;
  localparam int DIV_STG = (DIVN_W + DIV_STEP - 1) / DIV_STEP;
  localparam int DIVP_W = DIV_STG * DIV_STEP;
  localparam int DIV_LAT = DIV_STG + 2;

  // divide by six: one 16-bit chunk per stage, reciprocal of three on 18 bits
  localparam int DIV6_CHK = 4;
  localparam int DIV6_LAT = DIV6_CHK + 1;
  localparam logic [17:0] RECIP3 = 18'd174763;

  localparam logic [1:0] REG_COEF_B = 2'd0;
  localparam logic [1:0] REG_COEF_C = 2'd1;
  localparam logic [1:0] REG_COEF_D = 2'd2;
  localparam logic [1:0] REG_COEF_E = 2'd3;

  typedef struct packed {
    logic signed [31:0] setpoint_speed;
    logic signed [31:0] tilt_angle;
    logic signed [31:0] tilt_rate;
    logic signed [31:0] wheel_speed;
  } in_t;

  typedef struct packed {
    logic signed [31:0] drive_torque;
    logic              saturated;
  } out_t;

  typedef struct packed {
    logic              clip;
    logic signed [63:0] v;
  } qres_t;

  typedef struct packed {
    logic clip;
    logic zero;
  } div_flags_t;

  // signed 64-bit value from a magnitude, clipped to range
  function automatic qres_t from_mag(input logic neg, input logic [127:0] m);
    qres_t r;
    if (!neg) begin
      if (m > MAG_LIM_P) begin
        r.clip = 1'b1;
        r.v = Q_MAX;
      end else begin
        r.clip = 1'b0;
        r.v = $signed(m[63:0]);
      end
    end else begin
      if (m > MAG_LIM_N) begin
        r.clip = 1'b1;
        r.v = Q_MIN;
      end else begin
        r.clip = 1'b0;
        r.v = $signed(64'd0 - m[63:0]);
      end
    end
    return r;
  endfunction

endpackage

FILE: sv/lbt_qmul.sv
// Pipelined Q-format multiplier, 64 x 33 signed, rounded and clipped to 64 bits.
module lbt_qmul (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [63:0]                  a,
  input  logic signed [lbt_pkg::MUL_B_W-1:0]  b,
  output logic signed [63:0]                  p,
  output logic                                clip
);
  import lbt_pkg::*;

  localparam int PW = 64 + MUL_B_W;

  logic [63:0]          am;
  logic [MUL_B_W-1:0]   bm;
  logic [31+MUL_B_W:0]  p0;
  logic [31+MUL_B_W:0]  p1;
  logic                 neg1;
  logic                 neg2;
  logic [PW-1:0]        prod;
  qres_t                r;

  assign am = a[63] ? 64'(-a) : 64'(a);
  assign bm = b[MUL_B_W-1] ? MUL_B_W'(-b) : MUL_B_W'(b);

  always_ff @(posedge clk) begin
    if (en) begin
      p0   <= am[31:0] * bm;
      p1   <= am[63:32] * bm;
      neg1 <= a[63] ^ b[MUL_B_W-1];
    end
  end

  // half an LSB of the result added before the shift: rounds half away from zero
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PW'(p0) + {p1, 32'd0} + (PW'(1) << (FRAC_BITS - 1));
      neg2 <= neg1;
    end
  end

  assign r = from_mag(neg2, 128'(prod >> FRAC_BITS));

  always_ff @(posedge clk) begin
    if (en) begin
      p    <= r.v;
      clip <= r.clip;
    end
  end

endmodule

FILE: sv/lbt_qdiv.sv
// Pipelined Q-format divider: restoring long division, a few quotient bits per stage.
module lbt_qdiv (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [63:0]       n,
  input  logic signed [63:0]       d,
  output logic signed [63:0]       q,
  output lbt_pkg::div_flags_t      flags
);
  import lbt_pkg::*;

  typedef struct packed {
    logic qneg;
    logic nneg;
    logic zero;
  } dctl_t;

  logic [63:0]        nm;
  logic [63:0]        dm;
  logic [DIVP_W-1:0]  dvd;
  logic [63:0]        rem [DIV_STG+1];
  logic [DIVP_W-1:0]  wrk [DIV_STG+1];
  logic [63:0]        dmr [DIV_STG+1];
  dctl_t              ctl [DIV_STG+1];
  qres_t              fm;

  assign nm  = n[63] ? 64'(-n) : 64'(n);
  assign dm  = d[63] ? 64'(-d) : 64'(d);
  // scaled numerator plus half the divisor: quotient rounds half away from zero
  assign dvd = DIVP_W'({nm, {FRAC_BITS{1'b0}}}) + DIVP_W'(dm >> 1);

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= '0;
      wrk[0] <= dvd;
      dmr[0] <= dm;
      ctl[0] <= {n[63] ^ d[63], n[63], d == 64'sd0};
    end
  end

  // wrk shifts dividend bits out at the top and quotient bits in at the bottom
  for (genvar s = 0; s < DIV_STG; s++) begin : g_stg
    logic [63:0]       r_n;
    logic [DIVP_W-1:0] w_n;

    always_comb begin
      logic [64:0] r;
      r_n = rem[s];
      w_n = wrk[s];
      for (int k = 0; k < DIV_STEP; k++) begin
        r   = {r_n, w_n[DIVP_W-1]};
        w_n = {w_n[DIVP_W-2:0], 1'b0};
        if (r >= {1'b0, dmr[s]}) begin
          r      = r - {1'b0, dmr[s]};
          w_n[0] = 1'b1;
        end
        r_n = r[63:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1] <= r_n;
        wrk[s+1] <= w_n;
        dmr[s+1] <= dmr[s];
        ctl[s+1] <= ctl[s];
      end
    end
  end

  assign fm = from_mag(ctl[DIV_STG].qneg, 128'(wrk[DIV_STG]));

  always_ff @(posedge clk) begin
    if (en) begin
      if (ctl[DIV_STG].zero) begin
        q     <= ctl[DIV_STG].nneg ? Q_MIN : Q_MAX;
        flags <= {1'b0, 1'b1};
      end else begin
        q     <= fm.v;
        flags <= {fm.clip, 1'b0};
      end
    end
  end

endmodule

FILE: sv/lookahead_balance_torque_top.sv
// Look-ahead balance torque law: register file, pipelined datapath, output beat.
// One beat per cycle while the torque output is not stalled; the depth is set by the
// speed-term chain: input stage, stage A, four three-stage multiplies, a five-stage
// divide by six, the 42-stage long divider, two adder stages and the output register.
// A stalled output freezes the pipe; the input register still fills once while stalled.
// Synchronous reset clears all valid bits and loads every coefficient with 1.0.
module lookahead_balance_torque_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                sample_valid,
  output logic                sample_ready,
  input  lbt_pkg::in_t        sample,
  output logic                torque_valid,
  input  logic                torque_ready,
  output lbt_pkg::out_t       torque
);
  import lbt_pkg::*;

  localparam int M      = MUL_LAT;
  localparam int D      = DIV_LAT;
  localparam int T_A    = 1;
  localparam int T_M1   = T_A + M;
  localparam int T_M2   = T_A + 2 * M;
  localparam int T_N1   = T_M2 + 1;
  localparam int T_M3   = T_A + 3 * M;
  localparam int T_N2   = T_M3 + 1;
  localparam int T_DA   = T_A + D;
  localparam int T_ST   = T_DA + M;
  localparam int T_6    = T_M2 + DIV6_LAT;
  localparam int T_P1   = T_6 + M;
  localparam int T_P2   = T_P1 + M;
  localparam int T_DEN  = T_P2 + 1;
  localparam int T_S    = T_DEN + D;
  localparam int T_F1   = T_S + 1;
  localparam int T_OUT  = T_F1 + 1;

  localparam int L_T    = M;
  localparam int L_TH   = D;
  localparam int L_THD  = 2 * M;
  localparam int L_N0   = 2 * M;
  localparam int L_TCB  = T_P2 - T_M1;
  localparam int L_N1   = M - 1;
  localparam int L_N2   = T_DEN - T_N2;
  localparam int L_TA   = T_S - T_DA;
  localparam int L_ST   = T_S - T_ST;

  function automatic qres_t sadd(input logic signed [63:0] a, input logic signed [63:0] b);
    logic signed [64:0] s;
    qres_t r;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      r.clip = 1'b1;
      r.v = s[64] ? Q_MIN : Q_MAX;
    end else begin
      r.clip = 1'b0;
      r.v = s[63:0];
    end
    return r;
  endfunction

  function automatic qres_t sneg(input logic signed [63:0] a);
    qres_t r;
    if (a == Q_MIN) begin
      r.clip = 1'b1;
      r.v = Q_MAX;
    end else begin
      r.clip = 1'b0;
      r.v = -a;
    end
    return r;
  endfunction

  // ---------------- configuration ----------------
  logic signed [31:0] coef_b;
  logic signed [31:0] coef_c;
  logic signed [31:0] coef_d;
  logic signed [31:0] coef_e;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b <= COEF_RESET;
      coef_c <= COEF_RESET;
      coef_d <= COEF_RESET;
      coef_e <= COEF_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_COEF_B: coef_b <= pwdata;
        REG_COEF_C: coef_c <= pwdata;
        REG_COEF_D: coef_d <= pwdata;
        REG_COEF_E: coef_e <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_COEF_B: prdata = coef_b;
      REG_COEF_C: prdata = coef_c;
      REG_COEF_D: prdata = coef_d;
      REG_COEF_E: prdata = coef_e;
      default:    prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  logic             en;
  logic [T_OUT:0]   vld;
  logic [T_F1:1]    clp;
  logic [T_F1:1]    zro;
  logic [T_F1:0]    injc;
  logic [T_F1:0]    injz;
  in_t              smp;

  assign en           = !vld[T_OUT] || torque_ready;
  assign sample_ready = en || !vld[0];
  assign torque_valid = vld[T_OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en || !vld[0]) vld[0] <= sample_valid;
      if (en) vld[T_OUT:1] <= vld[T_OUT-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en || !vld[0]) smp <= sample;
  end

  // sticky clip and divide-by-zero flags ride along with each beat
  always_ff @(posedge clk) begin
    if (en) begin
      clp <= {clp[T_F1-1:1] | injc[T_F1-1:1], injc[0]};
      zro <= {zro[T_F1-1:1] | injz[T_F1-1:1], injz[0]};
    end
  end

  // ---------------- stage A ----------------
  logic signed [32:0] dif;
  logic [32:0]        dmag;
  logic [32:0]        a_t;
  logic signed [63:0] a_num_a;
  logic signed [63:0] a_num_r;
  logic signed [63:0] a_num0;
  logic signed [31:0] a_th;
  logic signed [31:0] a_thd;

  assign dif  = 33'(smp.wheel_speed) - 33'(smp.setpoint_speed);
  assign dmag = dif[32] ? 33'(-dif) : 33'(dif);

  always_ff @(posedge clk) begin
    if (en) begin
      // speed horizon: half the speed error rounded, plus 1.2
      a_t     <= 33'(({1'b0, dmag} + 34'd1) >> 1) + 33'(K12);
      a_num_a <= -64'(smp.tilt_angle) - (64'(smp.tilt_rate) <<< 1);
      a_num_r <= -64'(smp.tilt_rate);
      a_num0  <= 64'(smp.setpoint_speed) - 64'(smp.wheel_speed);
      a_th    <= smp.tilt_angle;
      a_thd   <= smp.tilt_rate;
    end
  end

  // ---------------- delay lines ----------------
  logic [32:0]        t_d   [L_T];
  logic signed [31:0] th_d  [L_TH];
  logic signed [31:0] thd_d [L_THD];
  logic signed [63:0] n0_d  [L_N0];
  logic signed [63:0] tcb_d [L_TCB];
  logic signed [63:0] n1_d  [L_N1];
  logic signed [63:0] n2_d  [L_N2];
  logic signed [63:0] ta_d  [L_TA];
  logic signed [63:0] tr_d  [L_TA];
  logic signed [63:0] st_d  [L_ST];

  logic signed [63:0] t2, tcb, mtce, mth, t3, mt22, mthd, t36, p1, p2;
  logic signed [63:0] ta, tr, qc, stt, ts;
  logic               c_tt, c_tcb, c_tce, c_th, c_t3, c_t22, c_thd, c_p1, c_p2, c_st;
  div_flags_t         fa, fr, fc, fs;

  logic signed [63:0] den, n1, n2, s1, s2;
  logic               den_c, n1_c, n2_c, f1_c;

  always_ff @(posedge clk) begin
    if (en) begin
      t_d[0]   <= a_t;
      th_d[0]  <= a_th;
      thd_d[0] <= a_thd;
      n0_d[0]  <= a_num0;
      tcb_d[0] <= tcb;
      n1_d[0]  <= n1;
      n2_d[0]  <= n2;
      ta_d[0]  <= ta;
      tr_d[0]  <= tr;
      st_d[0]  <= stt;
      for (int i = 1; i < L_T; i++)   t_d[i]   <= t_d[i-1];
      for (int i = 1; i < L_TH; i++)  th_d[i]  <= th_d[i-1];
      for (int i = 1; i < L_THD; i++) thd_d[i] <= thd_d[i-1];
      for (int i = 1; i < L_N0; i++)  n0_d[i]  <= n0_d[i-1];
      for (int i = 1; i < L_TCB; i++) tcb_d[i] <= tcb_d[i-1];
      for (int i = 1; i < L_N1; i++)  n1_d[i]  <= n1_d[i-1];
      for (int i = 1; i < L_N2; i++)  n2_d[i]  <= n2_d[i-1];
      for (int i = 1; i < L_TA; i++)  ta_d[i]  <= ta_d[i-1];
      for (int i = 1; i < L_TA; i++)  tr_d[i]  <= tr_d[i-1];
      for (int i = 1; i < L_ST; i++)  st_d[i]  <= st_d[i-1];
    end
  end

  // ---------------- angle, rate and static terms ----------------
  logic signed [63:0] cd2;
  assign cd2 = {{31{coef_d[31]}}, coef_d, 1'b0};

  lbt_qdiv u_div_a (.clk, .en, .n(a_num_a), .d(cd2), .q(ta), .flags(fa));
  lbt_qdiv u_div_r (.clk, .en, .n(a_num_r), .d(cd2), .q(tr), .flags(fr));
  lbt_qdiv u_div_c (.clk, .en, .n(-64'(coef_c)), .d(64'(coef_d)), .q(qc), .flags(fc));
  lbt_qmul u_mul_st (.clk, .en, .a(qc), .b(33'(th_d[L_TH-1])), .p(stt), .clip(c_st));

  // ---------------- speed term ----------------
  lbt_qmul u_mul_tt  (.clk, .en, .a(64'(a_t)), .b(a_t), .p(t2), .clip(c_tt));
  lbt_qmul u_mul_tcb (.clk, .en, .a(64'(a_t)), .b(33'(coef_b)), .p(tcb), .clip(c_tcb));
  lbt_qmul u_mul_tce (.clk, .en, .a(64'(a_t)), .b(33'(coef_e)), .p(mtce), .clip(c_tce));
  lbt_qmul u_mul_th  (.clk, .en, .a(mtce), .b(33'(th_d[M-1])), .p(mth), .clip(c_th));
  lbt_qmul u_mul_t3  (.clk, .en, .a(t2), .b(t_d[L_T-1]), .p(t3), .clip(c_t3));
  // t^2/2: t^2 is never negative, so rounding is a plain add-and-shift
  lbt_qmul u_mul_t22 (.clk, .en, .a((t2 + 64'sd1) >>> 1), .b(33'(coef_e)), .p(mt22),
                      .clip(c_t22));
  lbt_qmul u_mul_thd (.clk, .en, .a(mt22), .b(33'(thd_d[L_THD-1])), .p(mthd), .clip(c_thd));

  // t^3/6 rounded is floor((t^3 + 3) / 6): a third of (t^3 + 3) / 2, taken one 16-bit
  // chunk per stage, top chunk first; t^3 is never negative
  logic [63:0] d6_w [DIV6_CHK+1];
  logic [1:0]  d6_r [DIV6_CHK+1];

  always_ff @(posedge clk) begin
    if (en) begin
      d6_w[0] <= (64'(t3) + 64'd3) >> 1;
      d6_r[0] <= 2'd0;
    end
  end

  for (genvar k = 0; k < DIV6_CHK; k++) begin : g_d6
    logic [17:0] v;
    logic [35:0] pr;
    logic [15:0] qd;
    logic [1:0]  rr;

    // v stays below 3 * 2^16, where the reciprocal multiply is exact
    assign v  = {d6_r[k], d6_w[k][63:48]};
    assign pr = 36'(v) * 36'(RECIP3);
    assign qd = 16'(pr >> 19);
    assign rr = 2'(v - 18'(qd) * 18'd3);

    always_ff @(posedge clk) begin
      if (en) begin
        d6_w[k+1] <= {d6_w[k][47:0], qd};
        d6_r[k+1] <= rr;
      end
    end
  end

  assign t36 = $signed(d6_w[DIV6_CHK]);

  lbt_qmul u_mul_p1  (.clk, .en, .a(t36), .b(33'(coef_e)), .p(p1), .clip(c_p1));
  lbt_qmul u_mul_p2  (.clk, .en, .a(p1), .b(33'(coef_d)), .p(p2), .clip(c_p2));

  always_ff @(posedge clk) begin
    qres_t ng;
    qres_t sm;
    if (en) begin
      ng   = sneg(mth);
      sm   = sadd(n0_d[L_N0-1], ng.v);
      n1   <= sm.v;
      n1_c <= ng.clip | sm.clip;
      ng   = sneg(mthd);
      sm   = sadd(n1_d[L_N1-1], ng.v);
      n2   <= sm.v;
      n2_c <= ng.clip | sm.clip;
      sm    = sadd(tcb_d[L_TCB-1], p2);
      den   <= sm.v;
      den_c <= sm.clip;
    end
  end

  lbt_qdiv u_div_s (.clk, .en, .n(n2_d[L_N2-1]), .d(den), .q(ts), .flags(fs));

  // ---------------- final sum ----------------
  always_ff @(posedge clk) begin
    qres_t sa;
    qres_t sb;
    if (en) begin
      sa   = sadd(st_d[L_ST-1], ta_d[L_TA-1]);
      sb   = sadd(tr_d[L_TA-1], ts);
      s1   <= sa.v;
      s2   <= sb.v;
      f1_c <= sa.clip | sb.clip;
    end
  end

  always_comb begin
    injc = '0;
    injz = '0;
    injc[T_M1]  = injc[T_M1] | c_tt | c_tcb | c_tce;
    injc[T_M2]  = injc[T_M2] | c_th | c_t3 | c_t22;
    injc[T_N1]  = injc[T_N1] | n1_c;
    injc[T_M3]  = injc[T_M3] | c_thd;
    injc[T_N2]  = injc[T_N2] | n2_c;
    injc[T_DA]  = injc[T_DA] | fa.clip | fr.clip | fc.clip;
    injz[T_DA]  = injz[T_DA] | fa.zero | fr.zero | fc.zero;
    injc[T_ST]  = injc[T_ST] | c_st;
    injc[T_P1]  = injc[T_P1] | c_p1;
    injc[T_P2]  = injc[T_P2] | c_p2;
    injc[T_DEN] = injc[T_DEN] | den_c;
    injc[T_S]   = injc[T_S] | fs.clip;
    injz[T_S]   = injz[T_S] | fs.zero;
    injc[T_F1]  = injc[T_F1] | f1_c;
  end

  qres_t              fsum;
  logic               fz;
  logic               fc_all;
  logic signed [31:0] res;
  logic               sat;

  always_comb begin
    fsum   = sadd(s1, s2);
    fz     = zro[T_F1] | injz[T_F1];
    fc_all = clp[T_F1] | injc[T_F1] | fsum.clip;
    // a zero divisor forces full scale with the sign of the sum
    if (fz) begin
      res = fsum.v[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      sat = 1'b1;
    end else if ($signed(fsum.v) > 64'sh0000_0000_7FFF_FFFF) begin
      res = 32'sh7FFF_FFFF;
      sat = 1'b1;
    end else if ($signed(fsum.v) < 64'shFFFF_FFFF_8000_0000) begin
      res = 32'sh8000_0000;
      sat = 1'b1;
    end else begin
      res = fsum.v[31:0];
      sat = fc_all;
    end
  end

  always_ff @(posedge clk) begin
    if (en) torque <= {res, sat};
  end

endmodule

FILE: sv/lbt_checker.sv
// Port-level checks for the torque block, bound to the top level.
`include "lookahead_balance_torque_top_assert.svh"

module lbt_checker (
  input logic        clk,
  input logic        rst,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [3:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        sample_ready,
  input logic        torque_valid,
  input logic        torque_ready
);

  // a waiting result beat is not withdrawn
  `LBT_ASSERT_NEXT(a_out_hold, torque_valid && !torque_ready, torque_valid)

  // an empty output side never blocks the input
  `LBT_ASSERT_NOW(a_in_free, !torque_valid, sample_ready)

  // nothing comes out straight after reset
  `LBT_ASSERT_NEXT_RST(a_rst_quiet, rst, !torque_valid)

  // a written coefficient reads back at the same address
  `LBT_ASSERT_NEXT(a_cfg_readback, psel && penable && pwrite,
                   !psel || (paddr[3:2] != $past(paddr[3:2])) || (prdata == $past(pwdata)))

endmodule

bind lookahead_balance_torque_top lbt_checker u_chk (.*);
